@@ src/vtkey_pkg.sv @@
`timescale 1ns / 1ps

package vtkey_pkg;

  // One received transaction: either a timer tick or a terminal byte.
  typedef struct packed {
    logic       is_tick;
    logic [7:0] data_byte;
  } item_t;

  // One decoded key.
  typedef struct packed {
    logic [3:0] key_code;
    logic [7:0] byte_value;
    logic       last;
  } key_t;

  localparam logic [7:0] ESC_BYTE     = 8'h1B;
  localparam logic [7:0] INTRO_CSI    = 8'h5B;  // '['
  localparam logic [7:0] INTRO_SS3    = 8'h4F;  // 'O'

  localparam logic [9:0] TIMEOUT_RESET = 10'd100;
  localparam logic [9:0] WAIT_MAX      = 10'h3FF;

  localparam logic [3:0] KC_PLAIN  = 4'd0;
  localparam logic [3:0] KC_ESCAPE = 4'd1;
  localparam logic [3:0] KC_UP     = 4'd2;
  localparam logic [3:0] KC_DOWN   = 4'd3;
  localparam logic [3:0] KC_RIGHT  = 4'd4;
  localparam logic [3:0] KC_LEFT   = 4'd5;
  localparam logic [3:0] KC_HOME   = 4'd6;
  localparam logic [3:0] KC_END    = 4'd7;
  localparam logic [3:0] KC_INSERT = 4'd8;
  localparam logic [3:0] KC_F1     = 4'd9;
  localparam logic [3:0] KC_F2     = 4'd10;
  localparam logic [3:0] KC_F3     = 4'd11;
  localparam logic [3:0] KC_F4     = 4'd12;

  // Final byte after '['; KC_PLAIN means the byte is not a known final.
  function automatic logic [3:0] csi_final(input logic [7:0] b);
    logic [3:0] code;
    begin
      case (b)
        8'h41:   code = KC_UP;      // 'A'
        8'h42:   code = KC_DOWN;    // 'B'
        8'h43:   code = KC_RIGHT;   // 'C'
        8'h44:   code = KC_LEFT;    // 'D'
        8'h48:   code = KC_HOME;    // 'H'
        8'h4B:   code = KC_END;     // 'K'
        8'h40:   code = KC_INSERT;  // '@'
        default: code = KC_PLAIN;
      endcase
      return code;
    end
  endfunction

  // Final byte after 'O'.
  function automatic logic [3:0] ss3_final(input logic [7:0] b);
    logic [3:0] code;
    begin
      case (b)
        8'h50:   code = KC_F1;  // 'P'
        8'h51:   code = KC_F2;  // 'Q'
        8'h52:   code = KC_F3;  // 'R'
        8'h53:   code = KC_F4;  // 'S'
        default: code = KC_PLAIN;
      endcase
      return code;
    end
  endfunction

  // Builds a key; the byte value is only carried for plain bytes.
  function automatic key_t make_key(input logic [3:0] code, input logic [7:0] value,
                                    input logic fin);
    key_t k;
    begin
      k.key_code   = code;
      k.byte_value = (code == KC_PLAIN) ? value : 8'h00;
      k.last       = fin;
      return k;
    end
  endfunction

endpackage

@@ src/vt_escape_key_decoder_core.sv @@
`timescale 1ns / 1ps

// Terminal escape-sequence key decoder.
//
// Input channel (item_valid / item_stall / item): each transaction is either
// one received byte or one timer tick. Output channel (key_valid / key_stall /
// key): each transaction is one decoded key; key.last marks the final key
// produced by an input transaction. An input may produce zero, one, two or
// three keys.
// Configuration: cfg_write loads cfg_data into the timeout register (ticks to
// wait for each next byte of a sequence). Write only while the block is idle.
//
// The input is registered in the input register; its keys are then written
// into the result queue, whose head entry is shown on the output.
// Throughput is one input per cycle for inputs that give at most one key,
// while the receiver does not stall; an input giving two or three keys
// occupies the four-entry result queue, and the input register holds further
// input until the queue has drained to at most one entry.
// When the receiver stalls, the queue keeps the current key steady and fills;
// the input side then stalls in turn.
// Reset (synchronous, rst high) empties the input register and the queue,
// returns the decoder to idle and loads the timeout with 100 ticks.
module vt_escape_key_decoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  vtkey_pkg::item_t    item,
  output logic                key_valid,
  input  logic                key_stall,
  output vtkey_pkg::key_t     key,
  input  logic                cfg_write,
  input  logic [9:0]          cfg_data
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_INTRO,
    PH_FINAL
  } phase_t;

  // Configuration.
  logic [9:0] timeout_ticks;

  // Input register.
  logic             s1_valid;
  vtkey_pkg::item_t s1_item;
  logic             s1_move;
  logic             accept;

  // Decoder state.
  phase_t     phase, phase_next;
  logic       intro_is_o, intro_is_o_next;
  logic [9:0] wait_count, wait_count_next;

  // Keys produced by the item in the input register.
  vtkey_pkg::key_t res [3];
  logic [1:0]      res_n;

  // Result queue: entry 0 is the head shown on the output.
  vtkey_pkg::key_t q [4];
  logic [2:0]      cnt;
  logic            pop;
  logic [2:0]      base;
  logic [1:0]      push_n;

  // The input register hands its item over once the queue has room for
  // the worst case of three keys, without looking at the output stall.
  assign s1_move    = s1_valid && (cnt <= 3'd1);
  assign item_stall = s1_valid && !s1_move;
  assign accept     = item_valid && !item_stall;

  assign key_valid = (cnt != 3'd0);
  assign key       = q[0];
  assign pop       = key_valid && !key_stall;
  assign base      = cnt - {2'b00, pop};
  assign push_n    = s1_move ? res_n : 2'd0;

  // Sequence decoding of the registered item.
  always_comb begin
    logic [9:0] wc_inc;
    logic [3:0] fcode;
    logic [7:0] b;
    b               = s1_item.data_byte;
    wc_inc          = (wait_count == vtkey_pkg::WAIT_MAX) ? wait_count : wait_count + 10'd1;
    fcode           = intro_is_o ? vtkey_pkg::ss3_final(b) : vtkey_pkg::csi_final(b);
    phase_next      = phase;
    intro_is_o_next = intro_is_o;
    wait_count_next = wait_count;
    res_n           = 2'd0;
    res[0]          = vtkey_pkg::make_key(vtkey_pkg::KC_PLAIN, b, 1'b1);
    res[1]          = vtkey_pkg::make_key(vtkey_pkg::KC_PLAIN, b, 1'b1);
    res[2]          = vtkey_pkg::make_key(vtkey_pkg::KC_PLAIN, b, 1'b1);
    case (phase)
      PH_INTRO, PH_FINAL: begin
        if (s1_item.is_tick) begin
          // Each tick counts towards the timeout; on expiry only ESC is sent.
          if (wc_inc >= timeout_ticks) begin
            phase_next      = PH_IDLE;
            wait_count_next = 10'd0;
            res[0]          = vtkey_pkg::make_key(vtkey_pkg::KC_ESCAPE, 8'h00, 1'b1);
            res_n           = 2'd1;
          end else begin
            wait_count_next = wc_inc;
          end
        end else if (phase == PH_INTRO) begin
          wait_count_next = 10'd0;
          if (b == vtkey_pkg::INTRO_CSI || b == vtkey_pkg::INTRO_SS3) begin
            phase_next      = PH_FINAL;
            intro_is_o_next = (b == vtkey_pkg::INTRO_SS3);
          end else begin
            phase_next = PH_IDLE;
            res[0]     = vtkey_pkg::make_key(vtkey_pkg::KC_ESCAPE, 8'h00, 1'b0);
            res[1]     = vtkey_pkg::make_key(vtkey_pkg::KC_PLAIN, b, 1'b1);
            res_n      = 2'd2;
          end
        end else begin
          phase_next      = PH_IDLE;
          wait_count_next = 10'd0;
          if (fcode != vtkey_pkg::KC_PLAIN) begin
            res[0] = vtkey_pkg::make_key(fcode, 8'h00, 1'b1);
            res_n  = 2'd1;
          end else begin
            // Unknown final: replay ESC, the introducer and the byte.
            res[0] = vtkey_pkg::make_key(vtkey_pkg::KC_ESCAPE, 8'h00, 1'b0);
            res[1] = vtkey_pkg::make_key(vtkey_pkg::KC_PLAIN,
                       intro_is_o ? vtkey_pkg::INTRO_SS3 : vtkey_pkg::INTRO_CSI, 1'b0);
            res[2] = vtkey_pkg::make_key(vtkey_pkg::KC_PLAIN, b, 1'b1);
            res_n  = 2'd3;
          end
        end
      end
      default: begin
        // Idle: ticks are ignored, ESC opens a sequence, anything else
        // passes straight through.
        phase_next = PH_IDLE;
        if (!s1_item.is_tick) begin
          if (b == vtkey_pkg::ESC_BYTE) begin
            phase_next      = PH_INTRO;
            wait_count_next = 10'd0;
          end else begin
            res_n = 2'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= vtkey_pkg::TIMEOUT_RESET;
      s1_valid      <= 1'b0;
      phase         <= PH_IDLE;
      intro_is_o    <= 1'b0;
      wait_count    <= 10'd0;
      cnt           <= 3'd0;
    end else begin
      if (cfg_write) begin
        timeout_ticks <= cfg_data;
      end
      s1_valid <= accept || (s1_valid && !s1_move);
      if (s1_move) begin
        phase      <= phase_next;
        intro_is_o <= intro_is_o_next;
        wait_count <= wait_count_next;
      end
      cnt <= base + {1'b0, push_n};
    end
  end

  // Payload registers: input item and queue entries.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
    for (int i = 0; i < 4; i++) begin
      logic [2:0] rel;
      rel = 3'(i) - base;
      if ((3'(i) >= base) && (rel < {1'b0, push_n})) begin
        q[i] <= res[rel[1:0]];
      end else if (pop && (i < 3)) begin
        q[i] <= q[(i + 1) % 4];
      end
    end
  end

endmodule
